// ----- hdl/tt_pkg.sv -----
// Shared types and constants of the text tokenizer.
package tt_pkg;

  // token kinds
  localparam logic [2:0] K_CHAR  = 3'd0;
  localparam logic [2:0] K_WS    = 3'd1;
  localparam logic [2:0] K_NL    = 3'd2;
  localparam logic [2:0] K_INT   = 3'd3;
  localparam logic [2:0] K_NUM   = 3'd4;
  localparam logic [2:0] K_IDENT = 3'd5;
  localparam logic [2:0] K_END   = 3'd6;

  // scan modes of an open run
  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_WS    = 3'd1;
  localparam logic [2:0] M_INT   = 3'd2;
  localparam logic [2:0] M_NUM   = 3'd3;
  localparam logic [2:0] M_IDENT = 3'd4;

  // datapath operations
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_PUSH  = 3'd1;
  localparam logic [2:0] OP_DRAIN = 3'd2;
  localparam logic [2:0] OP_CLOSE = 3'd3;
  localparam logic [2:0] OP_END   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_EMIT_WS = 2'd0;
  localparam logic [1:0] REG_EMIT_NL = 2'd1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_N     = 8'h6E;

  localparam logic [7:0] PAT_NEG_NAN [0:8] =
    '{8'h2D, 8'h6E, 8'h61, 8'h6E, 8'h28, 8'h69, 8'h6E, 8'h64, 8'h29};
  localparam logic [7:0] PAT_NAN [0:2] = '{8'h6E, 8'h61, 8'h6E};

  localparam logic [3:0] MAX_RESULTS = 4'd12;
  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0] op;
    logic       take;
    logic       pend_to_out;
    logic       out_last;
  } tt_cmd_t;

  typedef struct packed {
    logic done;
    logic final_byte;
    logic emit_want;
  } tt_status_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_ident_start(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CH_UNDER) || c[7];
  endfunction

endpackage

// ----- hdl/tt_if.sv -----
// Channel interfaces of the text tokenizer: text bytes, tokens, configuration.
interface tt_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;
  modport source (output valid, in_byte, end_of_text, input ready);
  modport sink (input valid, in_byte, end_of_text, output ready);
endinterface

interface tt_token_if #(parameter int LINE_BITS = 20, parameter int COLUMN_BITS = 16);
  logic                   valid;
  logic                   ready;
  logic [2:0]             token_kind;
  logic [7:0]             char_code;
  logic [LINE_BITS-1:0]   start_line;
  logic [COLUMN_BITS-1:0] start_column;
  logic [31:0]            start_offset;
  logic [15:0]            token_length;
  logic                   last_token;
  modport source (output valid, token_kind, char_code, start_line, start_column,
                  start_offset, token_length, last_token, input ready);
  modport sink (input valid, token_kind, char_code, start_line, start_column,
                start_offset, token_length, last_token, output ready);
endinterface

interface tt_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/tt_ctrl.sv -----
// Sequencer of the text tokenizer: accepts bytes, steps the scanner, stages results.
module tt_ctrl
  import tt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  tt_status_t status,
  output tt_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DRAIN = 3'd1;
  localparam logic [2:0] S_CLOSE = 3'd2;
  localparam logic [2:0] S_END   = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0] state, state_next;
  logic       pend_valid, pend_valid_next;
  logic       out_valid_next;
  logic [3:0] rcnt, rcnt_next;
  logic       exec;
  logic       room;

  assign exec = !out_valid || out_ready;
  assign room = rcnt < MAX_RESULTS;
  assign text_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (text_valid) begin
          cmd.op     = OP_PUSH;
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (exec) begin
          cmd.op = OP_DRAIN;
          if (status.done) state_next = status.final_byte ? S_CLOSE : S_FLUSH;
        end
      end
      S_CLOSE: begin
        if (exec) begin
          cmd.op     = OP_CLOSE;
          state_next = S_END;
        end
      end
      S_END: begin
        if (exec) begin
          cmd.op     = OP_END;
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (exec) begin
          cmd.pend_to_out = pend_valid;
          cmd.out_last    = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if ((cmd.op == OP_DRAIN || cmd.op == OP_CLOSE || cmd.op == OP_END) &&
        status.emit_want && room) begin
      cmd.take        = 1'b1;
      cmd.pend_to_out = pend_valid;
    end
  end

  always_comb begin
    out_valid_next  = cmd.pend_to_out ? 1'b1 : (out_ready ? 1'b0 : out_valid);
    pend_valid_next = cmd.take ? 1'b1 : (cmd.pend_to_out ? 1'b0 : pend_valid);
    rcnt_next       = (cmd.op == OP_PUSH) ? 4'd0 : (cmd.take ? rcnt + 4'd1 : rcnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      rcnt       <= 4'd0;
    end else begin
      state      <= state_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
      rcnt       <= rcnt_next;
    end
  end

endmodule

// ----- hdl/tt_datapath.sv -----
// Scanner datapath: lookahead buffer, position counters, open run and result registers.
module tt_datapath
  import tt_pkg::*;
#(
  parameter int LOOKAHEAD_DEPTH = 9,
  parameter int LINE_BITS       = 20,
  parameter int COLUMN_BITS     = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tt_cmd_t                cmd,
  output tt_status_t             status,
  input  logic [7:0]             in_byte,
  input  logic                   end_of_text,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic                   cfg_data,
  output logic [2:0]             token_kind,
  output logic [7:0]             char_code,
  output logic [LINE_BITS-1:0]   start_line,
  output logic [COLUMN_BITS-1:0] start_column,
  output logic [31:0]            start_offset,
  output logic [15:0]            token_length,
  output logic                   last_token
);

  localparam int CW = $clog2(LOOKAHEAD_DEPTH + 1);

  logic [7:0] la [LOOKAHEAD_DEPTH];
  logic [7:0] s1 [LOOKAHEAD_DEPTH];
  logic [7:0] s3 [LOOKAHEAD_DEPTH];
  logic [7:0] s9 [LOOKAHEAD_DEPTH];
  logic [CW-1:0] cnt;
  logic [2:0] mode, mode_next;
  logic [LINE_BITS-1:0] line, line_next, os_line, os_line_next;
  logic [COLUMN_BITS-1:0] col, col_next, os_col, os_col_next;
  logic [31:0] off, off_next, os_off, os_off_next;
  logic [15:0] olen, olen_next;
  logic pcr, pcr_next, final_r, emit_ws, emit_nl;

  logic [3:0] pop, adv;
  logic done, want, cont;
  logic [2:0] r_kind;
  logic [7:0] r_code;
  logic [LINE_BITS-1:0] r_line;
  logic [COLUMN_BITS-1:0] r_col;
  logic [31:0] r_off;
  logic [15:0] r_len;
  logic do_start, do_fixed, do_close;
  logic [2:0] start_mode, fix_kind;
  logic [7:0] fix_code;
  logic [3:0] fix_len;
  logic mm_neg, mm_nan, full_neg, full_nan;
  logic [7:0] c;

  // replay taps for the three pop widths
  always_comb begin
    for (int i = 0; i < LOOKAHEAD_DEPTH; i++) begin
      s1[i] = (i + 1 < LOOKAHEAD_DEPTH) ? la[(i + 1) % LOOKAHEAD_DEPTH] : la[i];
      s3[i] = (i + 3 < LOOKAHEAD_DEPTH) ? la[(i + 3) % LOOKAHEAD_DEPTH] : la[i];
      s9[i] = (i + 9 < LOOKAHEAD_DEPTH) ? la[(i + 9) % LOOKAHEAD_DEPTH] : la[i];
    end
  end

  always_comb begin
    mm_neg = 1'b0;
    mm_nan = 1'b0;
    for (int i = 0; i < 9; i++)
      if ((CW'(i) < cnt) && (la[i] != PAT_NEG_NAN[i])) mm_neg = 1'b1;
    for (int i = 0; i < 3; i++)
      if ((CW'(i) < cnt) && (la[i] != PAT_NAN[i])) mm_nan = 1'b1;
    full_neg = cnt >= CW'(9);
    full_nan = cnt >= CW'(3);
  end

  assign c = la[0];

  always_comb begin
    mode_next = mode;  line_next = line;  col_next = col;  off_next = off;
    os_line_next = os_line;  os_col_next = os_col;  os_off_next = os_off;
    olen_next = olen;  pcr_next = pcr;
    pop = 4'd0;  adv = 4'd0;  done = 1'b0;  want = 1'b0;  cont = 1'b0;
    r_kind = K_CHAR;  r_code = 8'd0;  r_line = line;  r_col = col;  r_off = off;
    r_len = 16'd0;
    do_start = 1'b0;  start_mode = M_IDLE;
    do_fixed = 1'b0;  fix_kind = K_CHAR;  fix_code = 8'd0;  fix_len = 4'd0;
    do_close = 1'b0;
    unique case (cmd.op)
      OP_DRAIN: begin
        if (pcr) begin
          if (cnt == '0 && !final_r) begin
            done = 1'b1;
          end else begin
            r_len = 16'd1;
            if (cnt != '0 && c == CH_LF) begin
              pop      = 4'd1;
              off_next = off + 32'd1;
              r_len    = 16'd2;
            end
            want = emit_nl;  r_kind = K_NL;
            r_line = os_line;  r_col = os_col;  r_off = os_off;
            pcr_next = 1'b0;
          end
        end else if (cnt == '0) begin
          done = 1'b1;
        end else if (mode != M_IDLE) begin
          priority case (mode)
            M_WS:  cont = (c == CH_SPACE) || (c == CH_TAB);
            M_INT: begin
              cont = is_digit(c) || (c == CH_DOT);
              if (c == CH_DOT) mode_next = M_NUM;
            end
            M_NUM: cont = is_digit(c);
            default: cont = is_ident_start(c) || is_digit(c);
          endcase
          if (cont) begin
            if (olen != LEN_MAX) olen_next = olen + 16'd1;
            pop = 4'd1;
            adv = 4'd1;
          end else begin
            do_close = 1'b1;
          end
        end else if (c == CH_SPACE || c == CH_TAB) begin
          do_start = 1'b1;  start_mode = M_WS;
        end else if (c == CH_LF) begin
          want = emit_nl;  r_kind = K_NL;  r_len = 16'd1;
          pop = 4'd1;
          line_next = line + LINE_BITS'(1);  col_next = '0;  off_next = off + 32'd1;
        end else if (c == CH_CR) begin
          os_line_next = line;  os_col_next = col;  os_off_next = off;
          pop = 4'd1;
          line_next = line + LINE_BITS'(1);  col_next = '0;  off_next = off + 32'd1;
          pcr_next = 1'b1;
        end else if (is_digit(c)) begin
          do_start = 1'b1;  start_mode = M_INT;
        end else if (c == CH_MINUS) begin
          if (cnt >= CW'(2) && is_digit(la[1])) begin
            do_start = 1'b1;  start_mode = M_INT;
          end else if (!mm_neg && full_neg) begin
            do_fixed = 1'b1;  fix_kind = K_NUM;  fix_len = 4'd9;
          end else if (!mm_neg && !final_r) begin
            done = 1'b1;
          end else begin
            do_fixed = 1'b1;  fix_kind = K_CHAR;  fix_code = c;  fix_len = 4'd1;
          end
        end else if (c == CH_N) begin
          if (!mm_nan && full_nan) begin
            do_fixed = 1'b1;  fix_kind = K_NUM;  fix_len = 4'd3;
          end else if (!mm_nan && !final_r) begin
            done = 1'b1;
          end else begin
            do_start = 1'b1;  start_mode = M_IDENT;
          end
        end else if (is_ident_start(c)) begin
          do_start = 1'b1;  start_mode = M_IDENT;
        end else begin
          do_fixed = 1'b1;  fix_kind = K_CHAR;  fix_code = c;  fix_len = 4'd1;
        end
      end
      OP_CLOSE: do_close = (mode != M_IDLE);
      OP_END: begin
        want = 1'b1;  r_kind = K_END;
      end
      default: ;
    endcase
    if (do_start) begin
      os_line_next = line;  os_col_next = col;  os_off_next = off;
      olen_next = 16'd1;  pop = 4'd1;  adv = 4'd1;  mode_next = start_mode;
    end
    if (do_fixed) begin
      want = 1'b1;  r_kind = fix_kind;  r_code = fix_code;
      r_len = {12'd0, fix_len};  pop = fix_len;  adv = fix_len;
    end
    if (do_close) begin
      want = (mode != M_WS) || emit_ws;
      priority case (mode)
        M_INT:   r_kind = K_INT;
        M_NUM:   r_kind = K_NUM;
        M_IDENT: r_kind = K_IDENT;
        default: r_kind = K_WS;
      endcase
      r_line = os_line;  r_col = os_col;  r_off = os_off;  r_len = olen;
      mode_next = M_IDLE;
    end
    if (adv != 4'd0) begin
      col_next = col + {{(COLUMN_BITS-4){1'b0}}, adv};
      off_next = off + {28'd0, adv};
    end
  end

  assign status.done       = done;
  assign status.final_byte = final_r;
  assign status.emit_want  = want;

  // lookahead buffer: push at the fill level, pop from the head
  always_ff @(posedge clk) begin
    if (cmd.op == OP_PUSH) begin
      for (int i = 0; i < LOOKAHEAD_DEPTH; i++)
        if (CW'(i) == cnt) la[i] <= in_byte;
    end else if (cmd.op == OP_DRAIN) begin
      for (int i = 0; i < LOOKAHEAD_DEPTH; i++) begin
        unique case (pop)
          4'd1:    la[i] <= s1[i];
          4'd3:    la[i] <= s3[i];
          4'd9:    la[i] <= s9[i];
          default: la[i] <= la[i];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.op == OP_END) begin
      cnt <= '0;  mode <= M_IDLE;  line <= '0;  col <= '0;  off <= '0;
      os_line <= '0;  os_col <= '0;  os_off <= '0;  olen <= '0;  pcr <= 1'b0;
      if (rst) final_r <= 1'b0;
    end else if (cmd.op == OP_PUSH) begin
      if (cnt < CW'(LOOKAHEAD_DEPTH)) cnt <= cnt + CW'(1);
      final_r <= end_of_text;
    end else begin
      cnt <= cnt - CW'(pop);
      mode <= mode_next;  line <= line_next;  col <= col_next;  off <= off_next;
      os_line <= os_line_next;  os_col <= os_col_next;  os_off <= os_off_next;
      olen <= olen_next;  pcr <= pcr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_ws <= 1'b0;
      emit_nl <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == REG_EMIT_WS) emit_ws <= cfg_data;
      if (cfg_index == REG_EMIT_NL) emit_nl <= cfg_data;
    end
  end

  // result staging: one held result plus the output register
  logic [2:0]             p_kind;
  logic [7:0]             p_code;
  logic [LINE_BITS-1:0]   p_line;
  logic [COLUMN_BITS-1:0] p_col;
  logic [31:0]            p_off;
  logic [15:0]            p_len;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      p_kind <= r_kind;  p_code <= r_code;  p_line <= r_line;
      p_col <= r_col;  p_off <= r_off;  p_len <= r_len;
    end
    if (cmd.pend_to_out) begin
      token_kind <= p_kind;  char_code <= p_code;  start_line <= p_line;
      start_column <= p_col;  start_offset <= p_off;  token_length <= p_len;
      last_token <= cmd.out_last;
    end
  end

endmodule

// ----- hdl/text_tokenizer_core.sv -----
// Top level of the text tokenizer: byte stream in, token stream out.
//
// Usage: bytes of a text arrive on the text channel, one request per byte,
// end_of_text set on the last one. Tokens leave on the tokens channel, each
// with kind, character code, start line, column, offset and length;
// last_token marks the final token caused by one byte. After the byte marked
// end_of_text come any open run and an end token, and the next byte starts a
// new text at line 0, column 0, offset 0.
// Configuration: the cfg channel is always ready; index 0 enables whitespace
// tokens, index 1 newline tokens. Write only while the block is idle.
// Sequence: a byte is accepted, then the scanner steps (roughly one step per
// token closed or byte consumed, plus one to find the buffer empty) and the
// results are staged; a replay of held lookahead bytes adds steps, and the
// last byte adds a close and an end step. The next byte is taken only once
// its predecessor is staged; the scanner sequencer in tt_ctrl sets this order.
// Output: a token appears in the cycle after the step that closes the next
// one, or once the final staging step of its byte is done.
// Reset: synchronous, clears counters, buffer fill, open run and both
// configuration registers. A stalled receiver holds the output register and
// halts the scanner; the next byte is still taken while a token waits.
module text_tokenizer_core
  import tt_pkg::*;
#(
  parameter int LOOKAHEAD_DEPTH = 9,
  parameter int LINE_BITS       = 20,
  parameter int COLUMN_BITS     = 16
) (
  input logic clk,
  input logic rst,
  tt_text_if.sink     text,
  tt_token_if.source  tokens,
  tt_cfg_if.sink      cfg
);

  tt_cmd_t    cmd;
  tt_status_t status;

  // accept configuration at once
  assign cfg.ready = 1'b1;

  tt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text.valid),
    .text_ready (text.ready),
    .out_ready  (tokens.ready),
    .out_valid  (tokens.valid),
    .status     (status),
    .cmd        (cmd)
  );

  tt_datapath #(
    .LOOKAHEAD_DEPTH (LOOKAHEAD_DEPTH),
    .LINE_BITS       (LINE_BITS),
    .COLUMN_BITS     (COLUMN_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_byte      (text.in_byte),
    .end_of_text  (text.end_of_text),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .token_kind   (tokens.token_kind),
    .char_code    (tokens.char_code),
    .start_line   (tokens.start_line),
    .start_column (tokens.start_column),
    .start_offset (tokens.start_offset),
    .token_length (tokens.token_length),
    .last_token   (tokens.last_token)
  );

  // hold off the next byte right after a request is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    text.valid && text.ready |=> !text.ready)
    else $error("byte accepted while scanner still busy");

  // only character tokens carry a code
  a_char_code: assert property (@(posedge clk) disable iff (rst)
    tokens.valid && tokens.token_kind != K_CHAR |-> tokens.char_code == 8'd0)
    else $error("non-character token with a code");

  // end token is empty and closes its byte's results
  a_end_token: assert property (@(posedge clk) disable iff (rst)
    tokens.valid && tokens.token_kind == K_END |->
      tokens.token_length == 16'd0 && tokens.last_token)
    else $error("malformed end token");

  // no token is shown with an unknown kind
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    tokens.valid |-> tokens.token_kind <= K_END)
    else $error("token kind out of range");

endmodule

// ----- tb/sv/tb_tokenizer_model.sv -----
`timescale 1ns / 100ps
// Behavioural predictor of the tokenizer: token kinds, positions and lengths per text byte.
package tb_tokenizer_model;
  import tt_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  code;
    logic [19:0] line;
    logic [15:0] column;
    logic [31:0] offset;
    logic [15:0] length;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [19:0] line;
    logic [15:0] column;
    logic [31:0] offset;
  } where_t;

  class tokenizer_predictor;
    bit          show_ws, show_nl;
    logic [2:0]  mode;
    logic [7:0]  held[9];
    int          held_n;
    where_t      cur, run_start;
    int unsigned run_len;
    bit          cr_open;
    token_t      out_q[$];

    function void clear();
      mode = M_IDLE; held_n = 0; cur = '0; run_start = '0; run_len = 0; cr_open = 0;
    endfunction

    function void push_token(logic [2:0] k, logic [7:0] c, where_t s, int unsigned n);
      token_t t;
      if (out_q.size() >= 12) return;
      t.kind = k; t.code = c; t.line = s.line; t.column = s.column; t.offset = s.offset;
      t.length = (n > 65535) ? 16'hFFFF : n[15:0];
      t.last = 0;
      out_q.push_back(t);
    endfunction

    function void drop_head();
      if (held_n == 0) return;
      for (int i = 0; i < 8; i++) held[i] = held[i+1];
      held_n--;
    endfunction

    function void col_step();
      cur.column++; cur.offset++;
    endfunction

    function int prefix_match(logic [7:0] pat[], int plen);
      for (int i = 0; i < plen && i < held_n; i++)
        if (held[i] != pat[i]) return 0;
      return (held_n >= plen) ? 2 : 1;
    endfunction

    function void open_run(logic [2:0] m);
      run_start = cur; run_len = 1; drop_head(); col_step(); mode = m;
    endfunction

    function void fixed(logic [2:0] k, logic [7:0] c, int n);
      push_token(k, c, cur, n);
      for (int i = 0; i < n; i++) begin
        drop_head(); col_step();
      end
    endfunction

    function void close_run();
      logic [2:0] k;
      k = (mode == M_INT) ? K_INT : (mode == M_NUM) ? K_NUM :
          (mode == M_IDENT) ? K_IDENT : K_WS;
      if (k != K_WS || show_ws) push_token(k, 8'h00, run_start, run_len);
      mode = M_IDLE;
    endfunction

    function void scan(bit fin);
      logic [7:0] c;
      logic [7:0] pneg[] = '{8'h2D, 8'h6E, 8'h61, 8'h6E, 8'h28, 8'h69, 8'h6E, 8'h64, 8'h29};
      logic [7:0] pnan[] = '{8'h6E, 8'h61, 8'h6E};
      bit          go_on;
      int          r;
      int unsigned n;
      where_t      s;
      forever begin
        if (cr_open) begin
          n = 1;
          if (held_n == 0 && !fin) return;
          if (held_n > 0 && held[0] == CH_LF) begin
            drop_head(); cur.offset++; n = 2;
          end
          if (show_nl) push_token(K_NL, 8'h00, run_start, n);
          cr_open = 0;
          continue;
        end
        if (held_n == 0) return;
        c = held[0];
        if (mode != M_IDLE) begin
          if (mode == M_WS) go_on = (c == CH_SPACE || c == CH_TAB);
          else if (mode == M_INT) begin
            go_on = is_digit(c) || c == CH_DOT;
            if (c == CH_DOT) mode = M_NUM;
          end else if (mode == M_NUM) go_on = is_digit(c);
          else go_on = is_ident_start(c) || is_digit(c);
          if (go_on) begin
            if (run_len < 65535) run_len++;
            drop_head(); col_step();
          end else close_run();
          continue;
        end
        if (c == CH_SPACE || c == CH_TAB) open_run(M_WS);
        else if (c == CH_LF) begin
          s = cur; drop_head();
          cur.line++; cur.column = 0; cur.offset++;
          if (show_nl) push_token(K_NL, 8'h00, s, 1);
        end else if (c == CH_CR) begin
          run_start = cur; drop_head();
          cur.line++; cur.column = 0; cur.offset++;
          cr_open = 1;
        end else if (is_digit(c)) open_run(M_INT);
        else if (c == CH_MINUS) begin
          if (held_n >= 2 && is_digit(held[1])) begin
            open_run(M_INT);
            continue;
          end
          r = prefix_match(pneg, 9);
          if (r == 2) fixed(K_NUM, 8'h00, 9);
          else if (r == 1 && !fin) return;
          else fixed(K_CHAR, c, 1);
        end else if (c == CH_N) begin
          r = prefix_match(pnan, 3);
          if (r == 2) fixed(K_NUM, 8'h00, 3);
          else if (r == 1 && !fin) return;
          else open_run(M_IDENT);
        end else if (is_ident_start(c)) open_run(M_IDENT);
        else fixed(K_CHAR, c, 1);
      end
    endfunction

    // Work out the tokens one text byte releases.
    function void take_byte(logic [7:0] b, bit eot, ref token_t res[$]);
      out_q.delete();
      if (held_n < 9) begin
        held[held_n] = b; held_n++;
      end
      scan(eot);
      if (eot) begin
        if (mode != M_IDLE) close_run();
        push_token(K_END, 8'h00, cur, 0);
        clear();
      end
      if (out_q.size() > 0) out_q[out_q.size()-1].last = 1;
      res = out_q;
    endfunction
  endclass
endpackage

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the tokenizer testbench: stimulus, token checker and run control.
module tb_top;
  import tt_pkg::*;
  import tb_tokenizer_model::*;

  logic clk = 0;
  logic rst = 1;

  tt_text_if  text_ch();
  tt_token_if #(.LINE_BITS(20), .COLUMN_BITS(16)) tok_ch();
  tt_cfg_if   cfg_ch();

  text_tokenizer_core dut (
    .clk(clk), .rst(rst), .text(text_ch), .tokens(tok_ch), .cfg(cfg_ch)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // One directed request: a byte, its end flag and, where obvious, the token it gives.
  typedef struct {
    logic [7:0] b;
    bit         eot;
    bit         known;
    token_t     tok;
  } byte_row_t;

  tokenizer_predictor predictor = new();
  token_t             pending_tokens[$];
  int                 fail_count = 0;
  int                 quiet_cycles = 0;
  int                 stall_left = 0;
  bit                 sink_ready_en = 1;
  byte_row_t          rows[$];

  initial begin
    text_ch.valid = 0; text_ch.in_byte = 0; text_ch.end_of_text = 0;
    tok_ch.ready = 0;
    cfg_ch.valid = 0; cfg_ch.index = REG_EMIT_WS; cfg_ch.data = 0;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Watchdog: abort when nothing moves for too long.
  always @(posedge clk) begin
    if ((text_ch.valid && text_ch.ready) || (tok_ch.valid && tok_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: stall at random, mostly short and now and then long.
  always @(posedge clk) begin
    if (rst || !sink_ready_en) begin
      tok_ch.ready <= 0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      tok_ch.ready <= 0;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 8) begin
      tok_ch.ready <= 0;
      stall_left   <= $urandom_range(0, 2);
    end else if ($urandom_range(0, 99) < 2) begin
      tok_ch.ready <= 0;
      stall_left   <= $urandom_range(10, 40);
    end else tok_ch.ready <= 1;
  end

  // Check every accepted token against the oldest expectation, field by field.
  always @(posedge clk) begin
    token_t want;
    if (!rst && tok_ch.valid && tok_ch.ready) begin
      if (pending_tokens.size() == 0) report_mismatch("unexpected token", tok_ch.token_kind, 0);
      else begin
        want = pending_tokens.pop_front();
        if (tok_ch.token_kind !== want.kind) report_mismatch("kind", tok_ch.token_kind, want.kind);
        if (tok_ch.char_code !== want.code) report_mismatch("char", tok_ch.char_code, want.code);
        if (tok_ch.start_line !== want.line) report_mismatch("line", tok_ch.start_line, want.line);
        if (tok_ch.start_column !== want.column)
          report_mismatch("column", tok_ch.start_column, want.column);
        if (tok_ch.start_offset !== want.offset)
          report_mismatch("offset", tok_ch.start_offset, want.offset);
        if (tok_ch.token_length !== want.length)
          report_mismatch("length", tok_ch.token_length, want.length);
        if (tok_ch.last_token !== want.last)
          report_mismatch("last", tok_ch.last_token, want.last);
      end
    end
  end

  // Write one register; only called while the block is idle.
  task automatic write_reg(logic [1:0] idx, bit val);
    cfg_ch.valid <= 1; cfg_ch.index <= idx; cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
    if (idx == REG_EMIT_WS) predictor.show_ws = val;
    else predictor.show_nl = val;
    @(posedge clk);
  endtask

  // Send one byte with a random gap before it; queue what it should give.
  task automatic send_byte(logic [7:0] b, bit eot, bit known = 0, token_t tok = '0);
    token_t res[$];
    int     gap;
    gap = ($urandom_range(0, 9) < 7) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 30);
    repeat (gap) @(posedge clk);
    text_ch.valid <= 1; text_ch.in_byte <= b; text_ch.end_of_text <= eot;
    predictor.take_byte(b, eot, res);
    if (known && (res.size() != 1 || res[0] !== tok))
      report_mismatch("directed table", res.size(), 1);
    foreach (res[i]) pending_tokens.push_back(res[i]);
    do @(posedge clk); while (!text_ch.ready);
    text_ch.valid <= 0;
    @(posedge clk);
  endtask

  task automatic settle();
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick_byte();
    // Mostly lexically interesting bytes, some fully random.
    case ($urandom_range(0, 11))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_CR;
      4: return CH_MINUS;
      5: return CH_DOT;
      6: return CH_N;
      7: return 8'h30 + $urandom_range(0, 9);
      8: return 8'h61 + $urandom_range(0, 25);
      9: return 8'h80 + $urandom_range(0, 127);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  initial begin
    token_t t;
    string  words[$] = '{"nan", "-nan(ind)", "-12", "3.14", "abc_9", " \t ", "\r\n", "\r",
                         "\n", "-nan(x", "na", "-", "1.2.3", "nanx", "-x", "_q", "(",
                         "\r\r", "-nan(ind", "007"};
    predictor.clear();
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed table: lone bytes each closing a text, checked by the predictor only.
    t = '{K_CHAR, 8'h00, 0, 0, 0, 1, 0};
    rows.push_back('{8'h00, 1, 0, t});   // char then end: two tokens, predictor only
    rows.push_back('{8'hFF, 1, 0, t});   // identifier from a high byte
    rows.push_back('{CH_MINUS, 1, 0, t}); // minus cut off by the end of text
    rows.push_back('{CH_CR, 1, 0, t});   // trailing CR, newline dropped here
    foreach (rows[i]) send_byte(rows[i].b, rows[i].eot, rows[i].known, rows[i].tok);
    // A space with whitespace off yields only the end token at column 1.
    t = '{K_END, 8'h00, 0, 1, 1, 0, 1};
    send_byte(CH_SPACE, 1, 1, t);
    settle();

    // Walk the settings, extremes included; every register written.
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(REG_EMIT_WS, phase[0]);
      write_reg(REG_EMIT_NL, phase[1]);
      foreach (words[i]) if (phase == 3 || i % 4 == phase) send_text(words[i]);
      settle();
    end

    // Long identifier to push the length towards saturation is too slow; use a moderate one.
    for (int i = 0; i < 60; i++) send_byte("a", i == 59);
    settle();

    // Random texts: mostly picked bytes, some well-formed keyword fragments.
    for (int n = 0; n < 250; ) begin
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_EMIT_WS, $urandom_range(0, 1));
        write_reg(REG_EMIT_NL, $urandom_range(0, 1));
      end
      for (int k = $urandom_range(3, 25); k > 0; k--) begin
        if ($urandom_range(0, 4) == 0) begin
          string w;
          w = words[$urandom_range(0, words.size() - 1)];
          for (int i = 0; i < w.len(); i++) send_byte(w[i], 0);
          n += w.len();
        end else begin
          send_byte(pick_byte(), 0);
          n++;
        end
      end
      send_byte(pick_byte(), 1);
      n++;
      settle();
    end

    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
